[design/clfs_pkg.sv]
package clfs_pkg;

	// Width of the declared body length; it saturates at all ones
	localparam int LENGTH_BITS = 24;
	localparam int TOKEN_LEN   = 15;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UPPER_C = 8'h43;

	// One result item: a body byte and its marks
	typedef struct packed {
		logic [7:0] body_byte;
		logic       last_of_frame;
		logic       length_clipped;
	} res_t;

	// Byte expected at each place of the "Content-Length:" token
	function automatic logic [7:0] token_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			4'd14:   c = ":";
			default: c = "C";
		endcase
		return c;
	endfunction

endpackage

[design/clfs_parser.sv]
module clfs_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic [7:0]         in_byte,
	input  logic               adv,
	output logic               res_valid,
	output clfs_pkg::res_t     res
);
	import clfs_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_SPACES = 3'd1,
		PH_DIGITS = 3'd2,
		PH_HDREND = 3'd3,
		PH_BODY   = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t     ph;
		logic [3:0] mp;
	} hdr_t;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	phase_t                 phase_q, phase_d;
	logic [3:0]             match_q, match_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic                   clip_q, clip_d;
	logic                   fire;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [LENGTH_BITS+3:0] acc;
	logic [LENGTH_BITS-1:0] rem_dec;
	logic [3:0]             tok_pos;
	hdr_t                   blank;

	// Advance the CR LF CR LF search by one byte
	function automatic hdr_t blank_step(input logic [1:0] pos, input logic [7:0] b,
			input logic nz);
		hdr_t       r;
		logic [7:0] want;
		want = pos[0] ? CH_LF : CH_CR;
		r.ph = PH_HDREND;
		if (b == want) begin
			if (pos == 2'd3) begin
				r.mp = 4'd0;
				r.ph = nz ? PH_BODY : PH_HUNT;
			end else begin
				r.mp = {2'b00, pos + 2'd1};
			end
		end else begin
			r.mp = (b == CH_CR) ? 4'd1 : 4'd0;
		end
		return r;
	endfunction

	assign fire  = valid_s1 & adv;
	assign stall = valid_s1 & ~adv;

	// Hold the input byte until the result side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Decode the byte and form the saturating decimal accumulate
	always_comb begin
		is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		digit    = byte_s1[3:0] - CH_ZERO[3:0];
		acc      = {1'b0, rem_q, 3'b000} + {3'b000, rem_q, 1'b0}
			+ {{LENGTH_BITS{1'b0}}, digit};
		rem_dec  = (rem_q != '0) ? rem_q - LENGTH_BITS'(1) : rem_q;
		tok_pos  = (match_q >= 4'(TOKEN_LEN)) ? 4'd0 : match_q;
		blank    = blank_step((phase_q == PH_HDREND) ? match_q[1:0] : 2'd0, byte_s1,
			rem_q != '0);
	end

	// Next state and result for the byte in the input register
	always_comb begin
		phase_d   = phase_q;
		match_d   = match_q;
		rem_d     = rem_q;
		clip_d    = clip_q;
		res_valid = 1'b0;
		res.body_byte      = byte_s1;
		res.last_of_frame  = (rem_dec == '0);
		res.length_clipped = clip_q;
		case (phase_q)
			PH_SPACES: begin
				if (byte_s1 == CH_SPACE) begin
					phase_d = PH_SPACES;
				end else if (is_digit) begin
					rem_d   = {{(LENGTH_BITS-4){1'b0}}, digit};
					phase_d = PH_DIGITS;
				end else begin
					phase_d = blank.ph;
					match_d = blank.mp;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					if (acc[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
						rem_d  = '1;
						clip_d = 1'b1;
					end else begin
						rem_d = acc[LENGTH_BITS-1:0];
					end
				end else begin
					phase_d = blank.ph;
					match_d = blank.mp;
				end
			end
			PH_HDREND: begin
				phase_d = blank.ph;
				match_d = blank.mp;
			end
			PH_BODY: begin
				rem_d     = rem_dec;
				res_valid = 1'b1;
				if (rem_dec == '0) begin
					phase_d = PH_HUNT;
					match_d = 4'd0;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (byte_s1 == token_char(tok_pos)) begin
					if (tok_pos == 4'(TOKEN_LEN - 1)) begin
						phase_d = PH_SPACES;
						match_d = 4'd0;
						rem_d   = '0;
						clip_d  = 1'b0;
					end else begin
						match_d = tok_pos + 4'd1;
					end
				end else begin
					match_d = (byte_s1 == CH_UPPER_C) ? 4'd1 : 4'd0;
				end
			end
		endcase
		res_valid = res_valid & fire;
	end

	// Commit the state once the byte is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			match_q <= 4'd0;
			rem_q   <= '0;
			clip_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			match_q <= match_d;
			rem_q   <= rem_d;
			clip_q  <= clip_d;
		end
	end

endmodule

[design/clfs_out_reg.sv]
module clfs_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_valid,
	input  clfs_pkg::res_t res,
	output logic           adv,
	output logic           body_valid,
	input  logic           body_stall,
	output logic [7:0]     body_byte,
	output logic           last_of_frame,
	output logic           length_clipped
);
	import clfs_pkg::*;

	logic valid_s2;
	res_t res_s2;

	// Take a new result whenever the register is empty or being drained
	assign adv = ~valid_s2 | ~body_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_s2 <= res;
		end
	end

	assign body_valid     = valid_s2;
	assign body_byte      = res_s2.body_byte;
	assign last_of_frame  = res_s2.last_of_frame;
	assign length_clipped = res_s2.length_clipped;

endmodule

[design/content_length_frame_splitter.sv]
// A body byte passes through the input register and then the result register
// on its way to the outputs.
// Throughput: one byte per cycle; the input register and the result register
// form a two-stage pipeline, so input stalls only while a result waits.
// Header bytes and bytes outside frames produce no result.
// Reset (arst_n, asynchronous, active low) empties both stages and returns
// the parser to hunting for the header token.
module content_length_frame_splitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       stall,
	input  logic [7:0] in_byte,
	output logic       body_valid,
	input  logic       body_stall,
	output logic [7:0] body_byte,
	output logic       last_of_frame,
	output logic       length_clipped
);
	import clfs_pkg::*;

	logic res_valid;
	res_t res;
	logic adv;

	// Parse one byte per cycle while not stalled
	clfs_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.stall     (stall),
		.in_byte   (in_byte),
		.adv       (adv),
		.res_valid (res_valid),
		.res       (res)
	);

	// Hold results for the downstream side
	clfs_out_reg u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.res_valid      (res_valid),
		.res            (res),
		.adv            (adv),
		.body_valid     (body_valid),
		.body_stall     (body_stall),
		.body_byte      (body_byte),
		.last_of_frame  (last_of_frame),
		.length_clipped (length_clipped)
	);

endmodule

[tb/sv/tb_content_length_frame_splitter.sv]
module tb_content_length_frame_splitter;
	import clfs_pkg::*;

	typedef enum logic [2:0] {
		HUNT_TOKEN,
		SKIP_SPACES,
		READ_LENGTH,
		FIND_BLANK,
		PASS_BODY
	} parse_phase_t;

	localparam logic [8*TOKEN_LEN-1:0] TOKEN_TEXT = "Content-Length:";
	localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 10;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       valid = 1'b0;
	logic       stall;
	logic [7:0] in_byte = 8'h00;
	logic       body_valid;
	logic       body_stall = 1'b0;
	logic [7:0] body_byte;
	logic       last_of_frame;
	logic       length_clipped;

	// Parser state mirrored from the block
	parse_phase_t           phase_q   = HUNT_TOKEN;
	logic [3:0]             match_pos = '0;
	logic [LENGTH_BITS-1:0] body_left = '0;
	logic                   clipped   = 1'b0;

	logic [7:0] pending_bytes[$];
	res_t       body_expect[$];
	res_t       want;

	bit calm     = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done;
	int send_gap;
	int stall_left;
	int hold_left;
	int gap_draw;
	int idle_cycles = 0;
	int errors = 0;
	int bytes_queued = 0;
	int bytes_sent = 0;
	int bytes_checked = 0;
	int clipped_seen = 0;
	int frames_queued = 0;

	content_length_frame_splitter u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid          (valid),
		.stall          (stall),
		.in_byte        (in_byte),
		.body_valid     (body_valid),
		.body_stall     (body_stall),
		.body_byte      (body_byte),
		.last_of_frame  (last_of_frame),
		.length_clipped (length_clipped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] token_at(input int p);
		return TOKEN_TEXT[8*(TOKEN_LEN-1-p) +: 8];
	endfunction

	// Mostly short gaps, a few long ones, none in calm stretches
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the CR LF CR LF search by one byte
	task automatic blank_line_byte(input logic [7:0] b);
		logic [1:0] pos;
		logic [7:0] need;
		pos = match_pos[1:0];
		need = pos[0] ? CH_LF : CH_CR;
		if (b == need) begin
			if (pos == 2'd3) begin
				match_pos = '0;
				phase_q = (body_left != '0) ? PASS_BODY : HUNT_TOKEN;
			end else begin
				match_pos = {2'b00, pos + 2'd1};
			end
		end else begin
			match_pos = (b == CH_CR) ? 4'd1 : 4'd0;
		end
	endtask

	// Step the parser by one accepted byte; queue the body byte it yields
	task automatic apply_stream_byte(input logic [7:0] b);
		int              pos;
		longint unsigned digit;
		longint unsigned cur;
		res_t            r;
		digit = 64'(b) - 64'(CH_ZERO);
		case (phase_q)
			SKIP_SPACES: begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					body_left = LENGTH_BITS'(digit);
					phase_q = READ_LENGTH;
				end else if (b != CH_SPACE) begin
					phase_q = FIND_BLANK;
					match_pos = '0;
					blank_line_byte(b);
				end
			end
			READ_LENGTH: begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					cur = 64'(body_left);
					if (cur > (LEN_MAX - digit) / 64'd10) begin
						body_left = '1;
						clipped = 1'b1;
					end else begin
						body_left = LENGTH_BITS'(cur * 64'd10 + digit);
					end
				end else begin
					phase_q = FIND_BLANK;
					match_pos = '0;
					blank_line_byte(b);
				end
			end
			FIND_BLANK: blank_line_byte(b);
			PASS_BODY: begin
				if (body_left != '0)
					body_left = body_left - LENGTH_BITS'(1);
				r.body_byte = b;
				r.last_of_frame = (body_left == '0);
				r.length_clipped = clipped;
				body_expect.push_back(r);
				if (body_left == '0) begin
					phase_q = HUNT_TOKEN;
					match_pos = '0;
				end
			end
			default: begin
				pos = int'(match_pos);
				if (pos >= TOKEN_LEN)
					pos = 0;
				phase_q = HUNT_TOKEN;
				if (b == token_at(pos)) begin
					if (pos == TOKEN_LEN - 1) begin
						phase_q = SKIP_SPACES;
						match_pos = '0;
						body_left = '0;
						clipped = 1'b0;
					end else begin
						match_pos = 4'(pos + 1);
					end
				end else begin
					match_pos = (b == CH_UPPER_C) ? 4'd1 : 4'd0;
				end
			end
		endcase
	endtask

	// Sender: offer queued bytes, hold the request while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
			in_byte <= 8'h00;
			send_gap <= 0;
		end else begin
			if (valid && !stall) begin
				apply_stream_byte(in_byte);
				bytes_sent <= bytes_sent + 1;
			end
			if (!valid || !stall) begin
				if (send_gap != 0) begin
					valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_bytes.size() != 0) begin
					valid <= 1'b1;
					in_byte <= pending_bytes.pop_front();
					send_gap <= pick_gap();
				end else begin
					valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted body byte, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (body_valid && !body_stall) begin
				if (body_expect.size() == 0) begin
					$error("unexpected body byte %02h", body_byte);
					errors++;
				end else begin
					want = body_expect.pop_front();
					if (body_byte !== want.body_byte) begin
						$error("body_byte: expected %02h, got %02h", want.body_byte, body_byte);
						errors++;
					end
					if (last_of_frame !== want.last_of_frame) begin
						$error("last_of_frame: expected %0b, got %0b",
							want.last_of_frame, last_of_frame);
						errors++;
					end
					if (length_clipped !== want.length_clipped) begin
						$error("length_clipped: expected %0b, got %0b",
							want.length_clipped, length_clipped);
						errors++;
					end
					if (want.length_clipped)
						clipped_seen++;
					bytes_checked++;
				end
			end
			if (hold_left != 0) begin
				body_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_req && !hold_done) begin
				body_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (stall_left != 0) begin
				body_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				gap_draw = pick_gap();
				body_stall <= (gap_draw != 0);
				stall_left <= (gap_draw == 0) ? 0 : gap_draw - 1;
			end
		end
	end

	// Stop the run when work is pending but no request moves
	always @(posedge clk) begin
		if (arst_n && ((valid && !stall) || (body_valid && !body_stall))) begin
			idle_cycles <= 0;
		end else if (pending_bytes.size() != 0 || valid || body_expect.size() != 0) begin
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// Token, spaces, length digits, optional extra header line, optional broken blank line, blank line
	task automatic push_header(input string digits, input int spaces,
			input bit extra, input bit broken);
		for (int i = 0; i < TOKEN_LEN; i++)
			push_byte(token_at(i));
		repeat (spaces) push_byte(CH_SPACE);
		push_text(digits);
		if (extra)
			push_text("\r\nAccept: */*");
		if (broken)
			push_text("\r\n\r");
		push_text("\r\n\r\n");
		frames_queued++;
	endtask

	task automatic push_body(input int len);
		repeat (len) push_byte(8'($urandom_range(0, 255)));
	endtask

	// Mostly well-formed frames, some noise and broken tokens in between
	task automatic push_random_frame(input int min_len, input int max_len);
		int    len;
		int    roll;
		int    cut;
		string digits;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			push_body($urandom_range(1, 8));
		end else if (roll < 25) begin
			cut = $urandom_range(1, TOKEN_LEN - 1);
			for (int i = 0; i < cut; i++)
				push_byte(token_at(i));
			push_byte("x");
		end
		roll = $urandom_range(0, 99);
		if (roll < 8)
			len = 0;
		else if (roll < 85)
			len = $urandom_range(min_len, max_len);
		else
			len = $urandom_range(max_len, 3 * max_len);
		digits = $sformatf("%0d", len);
		if ($urandom_range(0, 9) == 0)
			digits = {"0", digits};
		if ($urandom_range(0, 24) == 0)
			digits = "";
		push_header(digits, $urandom_range(0, 3), $urandom_range(0, 3) == 0,
			$urandom_range(0, 4) == 0);
		if (digits != "")
			push_body(len);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || valid || body_expect.size() != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: field extremes and each parser corner
		push_header("3", 1, 1'b0, 1'b0);
		push_byte(8'h00);
		push_byte(8'hff);
		push_byte(CH_UPPER_C);
		push_header("1", 0, 1'b1, 1'b1);
		push_byte(8'haa);
		push_header("0", 2, 1'b0, 1'b0);
		push_header("", 1, 1'b0, 1'b0);
		push_text("Content-LengXCC");
		push_header("2", 0, 1'b0, 1'b0);
		push_byte(8'h55);
		push_byte(CH_CR);
		push_text("Content-Length:002\r\n\rX\r\n\r\n");
		frames_queued++;
		push_byte(CH_LF);
		push_byte(8'h80);
		push_text("Content-Length: 4x-y\r\n\r\n");
		frames_queued++;
		push_body(4);
		push_byte(8'hff);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(":");
		push_byte(8'h00);

		// Pause the sender until every body byte is back
		wait_drained();
		repeat (20) @(negedge clk);

		while (bytes_queued < 700)
			push_random_frame(1, 16);
		wait_drained();

		// Long receiver hold-off while the sender keeps offering
		hold_req = 1'b1;
		while (bytes_queued < 1000)
			push_random_frame(20, 60);
		wait_drained();

		// Back-to-back stretch with no idling on either side
		calm = 1'b1;
		while (bytes_queued < 1250)
			push_random_frame(1, 16);
		wait_drained();
		calm = 1'b0;

		while (bytes_queued < 1500)
			push_random_frame(1, 16);

		// Overlong length: saturates, body bytes carry the clipped mark
		push_header("167772160", 1, 1'b0, 1'b0);
		push_body(300);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (body_expect.size() != 0) begin
			$error("%0d body bytes never arrived", body_expect.size());
			errors++;
		end
		$display("Sent %0d stream bytes over %0d frame headers; checked %0d body bytes.",
			bytes_sent, frames_queued, bytes_checked);
		$display("Clipped body bytes: %0d; receiver hold-off %0d cycles; drained pauses taken.",
			clipped_seen, HOLD_CYCLES);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[content_length_frame_splitter.f]
design/clfs_pkg.sv
design/clfs_parser.sv
design/clfs_out_reg.sv
design/content_length_frame_splitter.sv
tb/sv/tb_content_length_frame_splitter.sv
